// ===== design/ppmfd_pkg.sv =====
// shared types, constants and register map for the ppm frame decoder
`default_nettype none
package ppmfd_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned CHAN_W = 12;
  localparam int unsigned GAP_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned IDX_W = $clog2(MAX_CHANNELS);
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    ST_RESYNC    = 3'd0,
    ST_FIRST     = 3'd1,
    ST_STORED    = 3'd2,
    ST_PUBLISHED = 3'd3,
    ST_DROPPED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_SYNC_MIN      = 2'd0,
    REG_PULSE_MIN     = 2'd1,
    REG_PULSE_MAX     = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } reg_idx_t;

  localparam logic [GAP_W-1:0]  SYNC_MIN_RST      = 16'd2200;
  localparam logic [CHAN_W-1:0] PULSE_MIN_RST     = 12'd950;
  localparam logic [CHAN_W-1:0] PULSE_MAX_RST     = 12'd2050;
  localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RST = 4'd8;

  typedef struct packed {
    logic [GAP_W-1:0]  sync_min;
    logic [CHAN_W-1:0] pulse_min;
    logic [CHAN_W-1:0] pulse_max;
    logic [CNT_W-1:0]  channel_count;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/ppmfd_if.sv =====
// word channels of the ppm frame decoder: edge input and decoded result
`default_nettype none
interface ppmfd_in_if;
  logic                             valid;
  logic                             ready;
  logic [ppmfd_pkg::TIME_W-1:0]     edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

interface ppmfd_out_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       status;
  logic [ppmfd_pkg::GAP_W-1:0]      interval;
  logic                             update_flag;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan0;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan1;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan2;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan3;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan4;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan5;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan6;
  logic [ppmfd_pkg::CHAN_W-1:0]     chan7;

  modport source (output valid, output status, output interval, output update_flag,
                  output chan0, output chan1, output chan2, output chan3,
                  output chan4, output chan5, output chan6, output chan7,
                  input ready);
  modport sink   (input valid, input status, input interval, input update_flag,
                  input chan0, input chan1, input chan2, input chan3,
                  input chan4, input chan5, input chan6, input chan7,
                  output ready);
endinterface
`default_nettype wire

// ===== design/ppmfd_regs.sv =====
// apb configuration registers of the ppm frame decoder
`default_nettype none
module ppmfd_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ppmfd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ppmfd_pkg::DATA_W-1:0]   pwdata,
  output logic      [ppmfd_pkg::DATA_W-1:0]   prdata,
  output logic                                pready,
  output ppmfd_pkg::cfg_t                     cfg
);

  ppmfd_pkg::cfg_t    cfg_r;
  ppmfd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = ppmfd_pkg::reg_idx_t'(paddr[ppmfd_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_min      <= ppmfd_pkg::SYNC_MIN_RST;
      cfg_r.pulse_min     <= ppmfd_pkg::PULSE_MIN_RST;
      cfg_r.pulse_max     <= ppmfd_pkg::PULSE_MAX_RST;
      cfg_r.channel_count <= ppmfd_pkg::CHANNEL_COUNT_RST;
    end else if (wr_en) begin
      case (idx)
        ppmfd_pkg::REG_SYNC_MIN:
          cfg_r.sync_min <= pwdata[ppmfd_pkg::GAP_W-1:0];
        ppmfd_pkg::REG_PULSE_MIN:
          cfg_r.pulse_min <= pwdata[ppmfd_pkg::CHAN_W-1:0];
        ppmfd_pkg::REG_PULSE_MAX:
          cfg_r.pulse_max <= pwdata[ppmfd_pkg::CHAN_W-1:0];
        ppmfd_pkg::REG_CHANNEL_COUNT:
          cfg_r.channel_count <= pwdata[ppmfd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ppmfd_pkg::REG_SYNC_MIN:
        prdata = {{(ppmfd_pkg::DATA_W-ppmfd_pkg::GAP_W){1'b0}}, cfg_r.sync_min};
      ppmfd_pkg::REG_PULSE_MIN:
        prdata = {{(ppmfd_pkg::DATA_W-ppmfd_pkg::CHAN_W){1'b0}}, cfg_r.pulse_min};
      ppmfd_pkg::REG_PULSE_MAX:
        prdata = {{(ppmfd_pkg::DATA_W-ppmfd_pkg::CHAN_W){1'b0}}, cfg_r.pulse_max};
      ppmfd_pkg::REG_CHANNEL_COUNT:
        prdata = {{(ppmfd_pkg::DATA_W-ppmfd_pkg::CNT_W){1'b0}}, cfg_r.channel_count};
      default:
        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ppm_frame_decoder.sv =====
// ppm frame decoder top level: edge register, decode step, result register
//
//  channel | direction | handshake      | word
//  in_ch   | sink      | valid / ready  | edge_time
//  out_ch  | source    | valid / ready  | status, interval, update_flag, chan0..chan7
//  cfg     | apb slave | psel / penable | sync_min, pulse_min, pulse_max, channel_count
//
// one word per cycle while the result is not stalled; a word is held in the edge register and
// is then decoded into the result register when the result is free to advance.
// frame state advances in that same step: one subtract, a few compares, buffer writes.
// reset (synchronous, active low) clears frame state, buffers and both valid bits.
// a stalled result holds the result register; the edge register still takes a word
// while it is empty, then in_ch.ready drops until the result moves.
`default_nettype none
module ppm_frame_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ppmfd_in_if.sink                            in_ch,
  ppmfd_out_if.source                         out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ppmfd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ppmfd_pkg::DATA_W-1:0]   pwdata,
  output logic      [ppmfd_pkg::DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int unsigned NCH = ppmfd_pkg::MAX_CHANNELS;
  localparam int unsigned CW  = ppmfd_pkg::CHAN_W;

  ppmfd_pkg::cfg_t cfg;

  ppmfd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // edge register
  logic                           in_vld_r;
  logic [ppmfd_pkg::TIME_W-1:0]   in_time_r;

  // frame state
  logic [ppmfd_pkg::TIME_W-1:0]   prev_time_r, prev_time_nxt;
  logic                           synced_r, synced_nxt;
  logic [ppmfd_pkg::CNT_W-1:0]    chan_idx_r, chan_idx_nxt;
  logic                           upd_r, upd_nxt;
  logic [CW-1:0]                  work_r [NCH];
  logic [CW-1:0]                  work_nxt [NCH];
  logic [CW-1:0]                  pub_r [NCH];
  logic [CW-1:0]                  pub_nxt [NCH];

  // result register
  logic                           out_vld_r;
  ppmfd_pkg::status_t             status_r, status_nxt;
  logic [ppmfd_pkg::GAP_W-1:0]    gap_r;

  logic                           advance;
  logic                           step;
  logic [ppmfd_pkg::GAP_W-1:0]    gap;
  logic [ppmfd_pkg::CNT_W-1:0]    frame_len;
  logic [ppmfd_pkg::CNT_W-1:0]    slot;
  logic [ppmfd_pkg::CNT_W-1:0]    slot_inc;
  logic                           is_sync;
  logic                           in_window;

  assign advance     = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  assign gap = in_time_r[ppmfd_pkg::GAP_W-1:0] - prev_time_r[ppmfd_pkg::GAP_W-1:0];

  always_comb begin
    if (cfg.channel_count == '0) begin
      frame_len = ppmfd_pkg::CNT_W'(1);
    end else if (cfg.channel_count > ppmfd_pkg::CNT_W'(NCH)) begin
      frame_len = ppmfd_pkg::CNT_W'(NCH);
    end else begin
      frame_len = cfg.channel_count;
    end
  end

  assign is_sync   = gap >= cfg.sync_min;
  assign in_window = (gap >= {{(ppmfd_pkg::GAP_W-CW){1'b0}}, cfg.pulse_min})
                  && (gap <= {{(ppmfd_pkg::GAP_W-CW){1'b0}}, cfg.pulse_max});
  // index left over from a longer frame setting restarts at zero
  assign slot      = (chan_idx_r >= frame_len) ? '0 : chan_idx_r;
  assign slot_inc  = slot + ppmfd_pkg::CNT_W'(1);

  always_comb begin
    prev_time_nxt = in_time_r;
    synced_nxt    = synced_r;
    chan_idx_nxt  = chan_idx_r;
    upd_nxt       = upd_r;
    status_nxt    = ppmfd_pkg::ST_DROPPED;
    work_nxt      = work_r;
    pub_nxt       = pub_r;
    if (synced_r) begin
      if (is_sync) begin
        chan_idx_nxt = '0;
        upd_nxt      = 1'b1;
        status_nxt   = ppmfd_pkg::ST_RESYNC;
      end else if (in_window) begin
        work_nxt[slot[ppmfd_pkg::IDX_W-1:0]] = gap[CW-1:0];
        if (slot_inc >= frame_len) begin
          for (int k = 0; k < NCH; k++) begin
            if (ppmfd_pkg::CNT_W'(k) < frame_len) begin
              pub_nxt[k] = work_nxt[k];
            end
          end
          chan_idx_nxt = '0;
          status_nxt   = ppmfd_pkg::ST_PUBLISHED;
        end else begin
          chan_idx_nxt = slot_inc;
          status_nxt   = ppmfd_pkg::ST_STORED;
        end
      end else begin
        synced_nxt = 1'b0;
        status_nxt = ppmfd_pkg::ST_DROPPED;
      end
    end else if (is_sync) begin
      synced_nxt   = 1'b1;
      chan_idx_nxt = '0;
      upd_nxt      = 1'b0;
      status_nxt   = ppmfd_pkg::ST_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      prev_time_r <= '0;
      synced_r    <= 1'b0;
      chan_idx_r  <= '0;
      upd_r       <= 1'b0;
      for (int k = 0; k < NCH; k++) begin
        work_r[k] <= '0;
        pub_r[k]  <= '0;
      end
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (step) begin
        prev_time_r <= prev_time_nxt;
        synced_r    <= synced_nxt;
        chan_idx_r  <= chan_idx_nxt;
        upd_r       <= upd_nxt;
        work_r      <= work_nxt;
        pub_r       <= pub_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_time_r <= in_ch.edge_time;
    end
    if (step) begin
      status_r <= status_nxt;
      gap_r    <= gap;
    end
  end

  // flag and channels come straight from state, which only moves with the result
  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = status_r;
  assign out_ch.interval    = gap_r;
  assign out_ch.update_flag = upd_r;
  assign out_ch.chan0       = pub_r[0];
  assign out_ch.chan1       = pub_r[1];
  assign out_ch.chan2       = pub_r[2];
  assign out_ch.chan3       = pub_r[3];
  assign out_ch.chan4       = pub_r[4];
  assign out_ch.chan5       = pub_r[5];
  assign out_ch.chan6       = pub_r[6];
  assign out_ch.chan7       = pub_r[7];

endmodule
`default_nettype wire

// ===== bench/ppmfd_decode_checker.sv =====
// checker for the ppm frame decoder: tracks decode state and compares every result word
module ppmfd_decode_checker
  import ppmfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ppmfd_in_if               in_ch,
  ppmfd_out_if              out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    status_t                             status;
    logic [GAP_W-1:0]                    interval;
    logic                                update_flag;
    logic [MAX_CHANNELS-1:0][CHAN_W-1:0] chans;
  } decode_t;

  cfg_t              cfg;
  logic [TIME_W-1:0] last_edge;
  logic              in_sync;
  logic              upd_bit;
  int                chan_idx;
  logic [CHAN_W-1:0] frame_buf [MAX_CHANNELS];
  logic [CHAN_W-1:0] shown [MAX_CHANNELS];
  decode_t           expected_q [$];
  int                errors = 0;

  assign fail_count = errors;

  function automatic decode_t decode_edge(logic [TIME_W-1:0] t);
    decode_t           r;
    logic [TIME_W-1:0] diff;
    logic [GAP_W-1:0]  gap;
    int                n;
    diff = t - last_edge;
    gap = diff[GAP_W-1:0];
    // zero channels behaves as one, anything past the buffer saturates
    n = (cfg.channel_count == 0) ? 1 :
        (cfg.channel_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg.channel_count);
    last_edge = t;
    if (in_sync) begin
      // sync test wins over the pulse window
      if (gap >= cfg.sync_min) begin
        chan_idx = 0;
        upd_bit = 1'b1;
        r.status = ST_RESYNC;
      end else if (gap >= cfg.pulse_min && gap <= cfg.pulse_max) begin
        if (chan_idx >= n) chan_idx = 0;
        frame_buf[chan_idx] = gap[CHAN_W-1:0];
        chan_idx++;
        if (chan_idx >= n) begin
          // only the first n entries move, the rest keep older widths
          for (int k = 0; k < n; k++) shown[k] = frame_buf[k];
          chan_idx = 0;
          r.status = ST_PUBLISHED;
        end else begin
          r.status = ST_STORED;
        end
      end else begin
        in_sync = 1'b0;
        r.status = ST_DROPPED;
      end
    end else if (gap >= cfg.sync_min) begin
      in_sync = 1'b1;
      chan_idx = 0;
      upd_bit = 1'b0;
      r.status = ST_FIRST;
    end else begin
      r.status = ST_DROPPED;
    end
    r.interval = gap;
    r.update_flag = upd_bit;
    for (int k = 0; k < MAX_CHANNELS; k++) r.chans[k] = shown[k];
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    decode_t           want;
    logic [CHAN_W-1:0] got_chan [MAX_CHANNELS];
    if (!rst_n) begin
      cfg = '{SYNC_MIN_RST, PULSE_MIN_RST, PULSE_MAX_RST, CHANNEL_COUNT_RST};
      last_edge = '0;
      in_sync = 1'b0;
      upd_bit = 1'b0;
      chan_idx = 0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        frame_buf[k] = '0;
        shown[k] = '0;
      end
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_SYNC_MIN:      cfg.sync_min = pwdata[GAP_W-1:0];
          REG_PULSE_MIN:     cfg.pulse_min = pwdata[CHAN_W-1:0];
          REG_PULSE_MAX:     cfg.pulse_max = pwdata[CHAN_W-1:0];
          REG_CHANNEL_COUNT: cfg.channel_count = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting so a word can never match itself
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, status %0d interval %0d",
                   $time, out_ch.status, out_ch.interval);
        end else begin
          want = expected_q.pop_front();
          got_chan = '{out_ch.chan0, out_ch.chan1, out_ch.chan2, out_ch.chan3,
                       out_ch.chan4, out_ch.chan5, out_ch.chan6, out_ch.chan7};
          check_field("status", want.status, out_ch.status);
          check_field("interval", want.interval, out_ch.interval);
          check_field("update_flag", want.update_flag, out_ch.update_flag);
          for (int k = 0; k < MAX_CHANNELS; k++)
            check_field($sformatf("chan%0d", k), want.chans[k], got_chan[k]);
        end
      end
      if (in_ch.valid && in_ch.ready) expected_q.push_back(decode_edge(in_ch.edge_time));
    end
    pending <= expected_q.size();
  end

endmodule

// ===== bench/tb_ppm_frame_decoder.sv =====
// testbench top for the ppm frame decoder: reset, register setup, edge stimulus, verdict
module tb_ppm_frame_decoder;
  import ppmfd_pkg::*;

  localparam int PHASE_WORDS = 160;
  localparam int N_PHASES    = 10;
  localparam int LONG_HOLD   = 60;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  int                n_fail;
  int                n_pending;
  bit                idle_on = 1'b0;
  bit                hold_req = 1'b0;
  int                words_sent = 0;
  logic [TIME_W-1:0] last_time = '0;
  logic [GAP_W-1:0]  sync_min_m = SYNC_MIN_RST;
  logic [CHAN_W-1:0] pmin_m = PULSE_MIN_RST;
  logic [CHAN_W-1:0] pmax_m = PULSE_MAX_RST;
  int                frame_n = MAX_CHANNELS;

  ppmfd_in_if  in_ch ();
  ppmfd_out_if out_ch ();

  ppm_frame_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppmfd_decode_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (n_fail),
    .pending    (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_edge(input logic [TIME_W-1:0] t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.edge_time <= t;
    last_time = t;
    words_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_gap(input logic [TIME_W-1:0] d);
    send_edge(last_time + d);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic reg_write(input reg_idx_t r, input logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // registers change only with the pipeline empty; upper data bits are junk
  task automatic program_regs(input logic [GAP_W-1:0] s, input logic [CHAN_W-1:0] lo,
                              input logic [CHAN_W-1:0] hi, input logic [CNT_W-1:0] c);
    logic [DATA_W-1:0] junk;
    drain();
    repeat (4) @(posedge clk);
    junk = $urandom;
    reg_write(REG_SYNC_MIN, {junk[31:16], s});
    reg_write(REG_PULSE_MIN, {junk[31:12], lo});
    reg_write(REG_PULSE_MAX, {junk[31:12], hi});
    reg_write(REG_CHANNEL_COUNT, {junk[31:4], c});
    psel <= 1'b0;
    penable <= 1'b0;
    sync_min_m = s;
    pmin_m = lo;
    pmax_m = hi;
    frame_n = (c == 0) ? 1 : (c > MAX_CHANNELS) ? MAX_CHANNELS : int'(c);
  endtask

  function automatic logic [TIME_W-1:0] sync_gap();
    logic [TIME_W-1:0] g;
    int unsigned       hi_g;
    hi_g = (sync_min_m > 62535) ? 65535 : sync_min_m + 3000;
    g = ($urandom_range(0, 3) == 0) ? sync_min_m : $urandom_range(sync_min_m, hi_g);
    // extra whole wraps of the 16-bit interval
    if ($urandom_range(0, 9) == 0) g[31:16] = 16'($urandom);
    return g;
  endfunction

  function automatic logic [TIME_W-1:0] pulse_gap();
    if (pmin_m > pmax_m) return $urandom_range(0, 4095);
    case ($urandom_range(0, 5))
      0:       return TIME_W'(pmin_m);
      1:       return TIME_W'(pmax_m);
      default: return $urandom_range(pmin_m, pmax_m);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] noise_gap();
    case ($urandom_range(0, 4))
      0:       return sync_min_m - 1;
      1:       return pmin_m - 1;
      2:       return pmax_m + 1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic run_frame();
    int k;
    send_gap(sync_gap());
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * frame_n + 1) : frame_n;
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 19) == 0) send_gap(noise_gap());
      else send_gap(pulse_gap());
    end
  endtask

  task automatic run_words(input int n, input bit may_idle);
    int stop;
    stop = words_sent + n;
    while (words_sent < stop) begin
      if (may_idle && $urandom_range(0, 7) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 9) < 7) begin
        run_frame();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) send_edge($urandom);
          else send_gap(noise_gap());
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [GAP_W-1:0]  s;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] hi;
    logic [CNT_W-1:0]  c;
    bit                calm;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.edge_time <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: a full frame, resync, drops on both sides of the window
    send_edge('0);
    send_gap(3000);
    send_gap(950);
    send_gap(2050);
    send_gap(1000);
    send_gap(1500);
    send_gap(1200);
    send_gap(1300);
    send_gap(1400);
    send_gap(2000);
    send_gap(2200);
    send_gap(949);
    send_gap(65535);
    send_gap(2051);
    send_edge(32'hFFFF_FFFF);
    send_edge(32'h0000_0898);
    send_gap(32'h0001_03E8);

    // sync threshold inside the pulse window, short frame publishes partially
    program_regs(1000, 950, 2050, 3);
    send_gap(5000);
    send_gap(1500);
    send_gap(960);
    send_gap(970);
    send_gap(980);

    // empty pulse window
    program_regs(2200, 3000, 100, 0);
    send_gap(1500);

    // zero channel count behaves as a one-channel frame and publishes chan0 only
    program_regs(2200, 950, 2050, 0);
    send_gap(4000);
    send_gap(1234);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: program_regs(SYNC_MIN_RST, PULSE_MIN_RST, PULSE_MAX_RST, CHANNEL_COUNT_RST);
        1: program_regs(1000, 950, 2050, 3);
        2: program_regs(16'h0000, 12'h000, 12'hFFF, 4'h0);
        3: program_regs(16'hFFFF, 12'hFFF, 12'hFFF, 4'hF);
        4: program_regs(2200, 3000, 100, 1);
        default: begin
          lo = CHAN_W'($urandom_range(0, 2500));
          hi = CHAN_W'($urandom_range(lo, 4095));
          if ($urandom_range(0, 5) == 0) {lo, hi} = {hi, lo};
          s = GAP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(hi + 1, hi + 3000));
          c = CNT_W'($urandom_range(0, 15));
          program_regs(s, lo, hi, c);
        end
      endcase
      calm = (p == N_PHASES - 1);
      idle_on = !calm && p != 1;
      // result side holds off while edges keep coming, so the input backs up
      if (p == 1) hold_req = 1'b1;
      if (p == 3) begin
        run_words(PHASE_WORDS / 2, 1'b1);
        drain();
        run_words(PHASE_WORDS / 2, 1'b1);
      end else begin
        run_words(PHASE_WORDS, !calm);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
